### design/xcr_pkg.sv
package xcr_pkg;

	localparam int PAYLOAD_BYTES = 128;

	localparam logic [7:0] B_SOH = 8'h01;
	localparam logic [7:0] B_EOT = 8'h04;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_NAK = 8'h15;
	localparam logic [7:0] B_CAN = 8'h18;

	localparam logic [1:0] K_TX = 2'd0;
	localparam logic [1:0] K_WR = 2'd1;
	localparam logic [1:0] K_ST = 2'd2;

	localparam logic [2:0] ST_DONE   = 3'd1;
	localparam logic [2:0] ST_CANCEL = 3'd2;
	localparam logic [2:0] ST_CSUM   = 3'd3;
	localparam logic [2:0] ST_SEQ    = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic       take_byte;
		logic       clear_burst;
		logic       bump_seq;
		logic       set_started;
		logic       clr_word;
		logic       next_word;
		logic       bump_offset;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       burst_empty;
		logic       burst_full_next;
		logic       started;
		logic       first_soh;
		logic       first_eot;
		logic       first_can;
		logic       sum_ok;
		logic       seq_ok;
		logic       last_word;
	} dp_sts_t;

endpackage

### design/xcr_datapath.sv
module xcr_datapath #(
	parameter int PAYLOAD_BYTES = xcr_pkg::PAYLOAD_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  xcr_pkg::dp_cmd_t  cmd,
	input  logic [7:0]        rx_byte,
	input  logic [31:0]       base_address,
	output xcr_pkg::dp_sts_t  sts,
	output logic [31:0]       word_address,
	output logic [31:0]       word_data
);
	localparam int WORDS = PAYLOAD_BYTES / 4;
	localparam int WW = $clog2(WORDS);
	localparam int FULL = PAYLOAD_BYTES + 4;
	localparam int SUM_END = PAYLOAD_BYTES + 3;
	localparam int CW = $clog2(FULL + 1);

	logic [CW-1:0] count_q;
	logic [7:0]    first_q, pkt_q, sum_q, seq_q;
	logic          started_q;
	logic [31:0]   offset_q;
	logic [WW-1:0] word_q;
	logic [31:0]   mem [WORDS];
	logic [31:0]   rd_q;
	logic [31:0]   addr_q, data_q;
	logic [31:0]   addr_next;
	logic [CW-1:0] p;
	logic [WW-1:0] wsel;
	logic [7:0]    seq_next;

	assign p = count_q - CW'(3);
	assign wsel = p[WW+1:2];
	assign seq_next = seq_q + 8'd1;
	assign addr_next = base_address + offset_q + {{(30-WW){1'b0}}, word_q, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			first_q <= '0;
			pkt_q <= '0;
			sum_q <= '0;
			seq_q <= '0;
			started_q <= 1'b0;
			offset_q <= '0;
			word_q <= '0;
			addr_q <= '0;
			data_q <= '0;
		end else begin
			if (cmd.take_byte) begin
				if (count_q == CW'(0)) first_q <= rx_byte;
				if (count_q == CW'(1)) pkt_q <= rx_byte;
				if (count_q >= CW'(3) && count_q < CW'(SUM_END)) sum_q <= sum_q + rx_byte;
				count_q <= count_q + CW'(1);
			end
			if (cmd.clear_burst) begin
				count_q <= '0;
				sum_q <= '0;
			end
			if (cmd.bump_seq) seq_q <= seq_next;
			if (cmd.set_started) started_q <= 1'b1;
			if (cmd.clr_word) word_q <= '0;
			else if (cmd.next_word) word_q <= word_q + WW'(1);
			if (cmd.next_word) begin
				addr_q <= addr_next;
				data_q <= rd_q;
			end
			if (cmd.bump_offset) offset_q <= offset_q + 32'(PAYLOAD_BYTES);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte && count_q >= CW'(3) && count_q < CW'(SUM_END)) begin
			case (p[1:0])
				2'd0: mem[wsel][7:0] <= rx_byte;
				2'd1: mem[wsel][15:8] <= rx_byte;
				2'd2: mem[wsel][23:16] <= rx_byte;
				default: mem[wsel][31:24] <= rx_byte;
			endcase
		end
		rd_q <= mem[word_q];
	end

	assign word_data = data_q;
	assign word_address = addr_q;

	always_comb begin
		sts.burst_empty = (count_q == '0);
		sts.burst_full_next = (count_q == CW'(FULL - 1));
		sts.started = started_q;
		sts.first_soh = (first_q == xcr_pkg::B_SOH);
		sts.first_eot = (first_q == xcr_pkg::B_EOT);
		sts.first_can = (first_q == xcr_pkg::B_CAN);
		sts.sum_ok = (sum_q == rx_byte);
		sts.seq_ok = (seq_next == pkt_q);
		sts.last_word = (word_q == WW'(WORDS - 1));
	end
endmodule

### design/xcr_ctrl.sv
module xcr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              operation,
	input  logic              out_ready,
	input  xcr_pkg::dp_sts_t  sts,
	output xcr_pkg::dp_cmd_t  cmd,
	output logic              in_ready,
	output logic              out_valid,
	output logic [1:0]        out_kind,
	output logic [7:0]        out_tx,
	output logic [2:0]        out_status,
	output logic              out_last,
	output logic              out_word
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_TX   = 7'b0000010,
		S_RD   = 7'b0000100,
		S_WR   = 7'b0001000,
		S_ST   = 7'b0010000,
		S_STOP = 7'b0100000,
		S_NEXT = 7'b1000000
	} state_t;

	state_t      state_q, after_q;
	logic [7:0]  tx_q [3];
	logic [1:0]  ntx_q, itx_q;
	logic [2:0]  st_q;
	logic        ovalid_q, olast_q;
	logic [1:0]  okind_q;
	logic [7:0]  otx_q;
	logic [2:0]  ost_q;
	logic        free;
	logic        load;
	logic        bad_pkt;

	assign free = !ovalid_q || out_ready;
	assign load = free && (state_q == S_TX || state_q == S_NEXT || state_q == S_WR ||
		state_q == S_ST);
	assign bad_pkt = sts.first_soh && (!sts.sum_ok || !sts.seq_ok);
	// after a stop, transfers are taken and dropped
	assign in_ready = (state_q == S_IDLE) || (state_q == S_STOP);
	assign out_valid = ovalid_q;
	assign out_kind = okind_q;
	assign out_tx = otx_q;
	assign out_status = ost_q;
	assign out_last = olast_q;
	assign out_word = (okind_q == xcr_pkg::K_WR);

	always_comb begin
		cmd = '0;
		if (state_q == S_IDLE && in_fire) begin
			cmd.take_byte = !operation;
			cmd.clear_burst = operation || sts.burst_full_next;
			cmd.set_started = !operation && sts.burst_full_next;
			cmd.bump_seq = !operation && sts.burst_full_next && sts.first_soh && sts.sum_ok;
			cmd.clr_word = 1'b1;
		end
		if (state_q == S_RD) cmd.next_word = 1'b0;
		if (state_q == S_WR && free) begin
			cmd.next_word = 1'b1;
			cmd.bump_offset = sts.last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			after_q <= S_IDLE;
			ntx_q <= '0;
			itx_q <= '0;
			st_q <= '0;
			ovalid_q <= 1'b0;
			olast_q <= 1'b0;
			okind_q <= '0;
			otx_q <= '0;
			ost_q <= '0;
			tx_q[0] <= '0;
			tx_q[1] <= '0;
			tx_q[2] <= '0;
		end else begin
			if (load) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_fire) begin
					itx_q <= '0;
					if (operation) begin
						state_q <= S_TX;
						if (sts.burst_empty) begin
							st_q <= '0;
							after_q <= S_IDLE;
							if (sts.started) begin
								tx_q[0] <= xcr_pkg::B_ACK;
								tx_q[1] <= xcr_pkg::B_ACK;
								ntx_q <= 2'd2;
							end else begin
								tx_q[0] <= xcr_pkg::B_NAK;
								ntx_q <= 2'd1;
							end
						end else begin
							tx_q[0] <= xcr_pkg::B_ACK;
							ntx_q <= 2'd1;
							if (sts.first_eot) begin
								st_q <= xcr_pkg::ST_DONE;
								after_q <= S_ST;
							end else if (sts.first_can) begin
								st_q <= xcr_pkg::ST_CANCEL;
								after_q <= S_ST;
							end else begin
								st_q <= '0;
								after_q <= S_IDLE;
							end
						end
					end else if (sts.burst_full_next) begin
						state_q <= S_TX;
						tx_q[0] <= xcr_pkg::B_ACK;
						tx_q[2] <= xcr_pkg::B_ACK;
						if (bad_pkt) begin
							tx_q[1] <= sts.started ? xcr_pkg::B_CAN : xcr_pkg::B_ACK;
							ntx_q <= sts.started ? 2'd2 : 2'd3;
							st_q <= sts.sum_ok ? xcr_pkg::ST_SEQ : xcr_pkg::ST_CSUM;
							after_q <= sts.started ? S_ST : S_NEXT;
						end else begin
							tx_q[1] <= xcr_pkg::B_ACK;
							ntx_q <= sts.started ? 2'd1 : 2'd3;
							st_q <= '0;
							after_q <= sts.first_soh ? S_RD : S_IDLE;
						end
					end
				end
				S_TX: if (free) begin
					okind_q <= xcr_pkg::K_TX;
					otx_q <= tx_q[itx_q];
					ost_q <= '0;
					itx_q <= itx_q + 2'd1;
					olast_q <= (itx_q + 2'd1 == ntx_q) && (after_q == S_IDLE);
					if (itx_q + 2'd1 == ntx_q) state_q <= after_q;
				end
				S_NEXT: if (free) begin
					okind_q <= xcr_pkg::K_TX;
					otx_q <= xcr_pkg::B_CAN;
					ost_q <= '0;
					olast_q <= 1'b0;
					state_q <= S_ST;
				end
				S_RD: state_q <= S_WR;
				S_WR: if (free) begin
					okind_q <= xcr_pkg::K_WR;
					otx_q <= '0;
					ost_q <= '0;
					olast_q <= sts.last_word;
					state_q <= sts.last_word ? S_IDLE : S_RD;
				end
				S_ST: if (free) begin
					okind_q <= xcr_pkg::K_ST;
					otx_q <= '0;
					ost_q <= st_q;
					olast_q <= 1'b1;
					state_q <= S_STOP;
				end
				S_STOP: state_q <= S_STOP;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/xmodem_checksum_receiver.sv
// The first result is registered after the input transfer moves the controller to S_TX;
// then one result per cycle while m_tready accepts, with each word write taking a memory
// read (S_RD) then the output register (S_WR). Throughput: one input per cycle for plain
// bytes; an end-of-burst input holds off further input until the controller is back in S_IDLE or S_STOP.
// Reset (arst_n low, asynchronous) clears all control and burst state.
module xmodem_checksum_receiver #(
	parameter int PAYLOAD_BYTES = xcr_pkg::PAYLOAD_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // tx_byte[7:0], write_address[39:8], write_data[71:40], status[74:72]
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	xcr_pkg::dp_cmd_t cmd;
	xcr_pkg::dp_sts_t sts;
	logic [31:0] base_q, waddr, wdata;
	logic [7:0]  tx;
	logic [2:0]  st;
	logic        word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_q <= '0;
		else if (cfg_valid) base_q <= cfg_data;
	end

	xcr_datapath #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rx_byte(s_tdata),
		.base_address(base_q), .sts(sts), .word_address(waddr), .word_data(wdata)
	);

	xcr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.operation(s_tuser), .out_ready(m_tready), .sts(sts), .cmd(cmd),
		.in_ready(s_tready), .out_valid(m_tvalid), .out_kind(m_tuser),
		.out_tx(tx), .out_status(st), .out_last(m_tlast), .out_word(word)
	);

	assign m_tdata = {5'd0, st, word ? wdata : 32'd0, word ? waddr : 32'd0, tx};
endmodule

### test/xmodem_checksum_receiver_test.sv
module xmodem_checksum_receiver_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx;
		logic [31:0] addr;
		logic [31:0] data;
		logic [2:0]  status;
		logic        last;
	} xfer_res_t;

	localparam int SH_TIMEOUT = 0;
	localparam int SH_SHORT   = 1;
	localparam int SH_FULL    = 2;

	localparam int PL_RANDOM = 0;
	localparam int PL_ZERO   = 1;
	localparam int PL_ONES   = 2;

	localparam int ITEMS = 400;

	typedef struct {
		int          shape;
		logic [7:0]  first;
		int          len;
		int          fill;
		bit          typed;
		logic [7:0]  exp_tx;
		bit          set_base;
		logic [31:0] base;
	} burst_row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = 0;
	logic        s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [31:0] cfg_data = 0;

	xmodem_checksum_receiver u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver state copy
	logic [31:0] rx_base;
	int          rx_count;
	logic [7:0]  rx_first;
	logic [7:0]  rx_pnum;
	logic [7:0]  rx_sum;
	logic [7:0]  rx_seq;
	bit          rx_started;
	logic [31:0] rx_offset;
	bit          rx_halted;
	logic [31:0] rx_payload [32];

	xfer_res_t step_out [$];
	xfer_res_t expected_results [$];
	int  errors = 0;
	int  results_seen = 0;
	int  items_sent = 0;
	bit  quiet = 0;
	bit  hold_armed = 1;
	bit  row_typed = 0;
	logic [7:0] row_tx = 0;

	function void emit(logic [1:0] k, logic [7:0] tx, logic [31:0] a, logic [31:0] d,
			logic [2:0] st);
		xfer_res_t r;
		r.kind = k;
		r.tx = tx;
		r.addr = a;
		r.data = d;
		r.status = st;
		r.last = 1'b0;
		step_out.push_back(r);
	endfunction

	function void halt_with(logic [2:0] st);
		emit(xcr_pkg::K_ST, '0, '0, '0, st);
		rx_halted = 1;
	endfunction

	function void finish_packet(logic [7:0] check);
		if (!rx_started) begin
			rx_started = 1;
			emit(xcr_pkg::K_TX, xcr_pkg::B_ACK, '0, '0, '0);
			emit(xcr_pkg::K_TX, xcr_pkg::B_ACK, '0, '0, '0);
		end
		emit(xcr_pkg::K_TX, xcr_pkg::B_ACK, '0, '0, '0);
		if (rx_first != xcr_pkg::B_SOH)
			return;
		if (rx_sum != check) begin
			emit(xcr_pkg::K_TX, xcr_pkg::B_CAN, '0, '0, '0);
			halt_with(xcr_pkg::ST_CSUM);
			return;
		end
		rx_seq = rx_seq + 8'd1;
		if (rx_seq != rx_pnum) begin
			emit(xcr_pkg::K_TX, xcr_pkg::B_CAN, '0, '0, '0);
			halt_with(xcr_pkg::ST_SEQ);
			return;
		end
		for (int w = 0; w < 32; w++)
			emit(xcr_pkg::K_WR, '0, rx_base + rx_offset + 32'(4 * w), rx_payload[w], '0);
		rx_offset = rx_offset + 32'(xcr_pkg::PAYLOAD_BYTES);
	endfunction

	function void xmodem_predict(bit op, logic [7:0] b);
		int pos;
		int p;
		step_out.delete();
		if (rx_halted)
			return;
		if (op) begin
			if (rx_count == 0) begin
				if (!rx_started)
					emit(xcr_pkg::K_TX, xcr_pkg::B_NAK, '0, '0, '0);
				else begin
					emit(xcr_pkg::K_TX, xcr_pkg::B_ACK, '0, '0, '0);
					emit(xcr_pkg::K_TX, xcr_pkg::B_ACK, '0, '0, '0);
				end
			end else begin
				emit(xcr_pkg::K_TX, xcr_pkg::B_ACK, '0, '0, '0);
				if (rx_first == xcr_pkg::B_EOT)
					halt_with(xcr_pkg::ST_DONE);
				else if (rx_first == xcr_pkg::B_CAN)
					halt_with(xcr_pkg::ST_CANCEL);
			end
			rx_count = 0;
			rx_sum = 0;
		end else begin
			pos = rx_count;
			if (pos == 0)
				rx_first = b;
			else if (pos == 1)
				rx_pnum = b;
			else if (pos >= 3 && pos < 131) begin
				p = pos - 3;
				rx_payload[p / 4][8 * (p % 4) +: 8] = b;
				rx_sum = rx_sum + b;
			end
			rx_count = pos + 1;
			if (rx_count >= 132) begin
				finish_packet(b);
				rx_count = 0;
				rx_sum = 0;
			end
		end
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].last = 1'b1;
	endfunction

	task send_item(bit op, logic [7:0] b);
		xfer_res_t r;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		xmodem_predict(op, b);
		if (row_typed && step_out.size() > 0) begin
			r = '0;
			r.kind = xcr_pkg::K_TX;
			r.tx = row_tx;
			r.last = 1'b1;
			expected_results.push_back(r);
		end else begin
			foreach (step_out[i])
				expected_results.push_back(step_out[i]);
		end
	endtask

	task write_base(logic [31:0] v);
		s_tvalid <= 0;
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		rx_base = v;
	endtask

	task send_packet(logic [7:0] first, logic [7:0] seq, int fill, bit bad_sum);
		logic [7:0] sum;
		logic [7:0] b;
		sum = 0;
		send_item(1'b0, first);
		send_item(1'b0, seq);
		send_item(1'b0, $urandom_range(0, 3) == 0 ? 8'($urandom) : ~seq);
		for (int i = 0; i < 128; i++) begin
			case (fill)
				PL_ZERO: b = 8'h00;
				PL_ONES: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			sum = sum + b;
			send_item(1'b0, b);
		end
		send_item(1'b0, bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
	endtask

	task send_short(logic [7:0] first, int len);
		if (len > 0)
			send_item(1'b0, first);
		for (int i = 1; i < len; i++)
			send_item(1'b0, 8'($urandom));
		send_item(1'b1, 8'($urandom));
	endtask

	function logic [7:0] plain_first();
		logic [7:0] f;
		f = 8'($urandom);
		while (f == xcr_pkg::B_EOT || f == xcr_pkg::B_CAN || f == xcr_pkg::B_SOH)
			f = 8'($urandom);
		return f;
	endfunction

	function bit check_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t mismatch %s: expected %h actual %h", $realtime, name, e, a);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk) begin : result_check
		xfer_res_t e;
		bit bad;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h %h last %b",
					$realtime, m_tuser, m_tdata, m_tlast);
				errors++;
			end else begin
				e = expected_results.pop_front();
				bad = check_field("kind", 32'(e.kind), 32'(m_tuser));
				bad |= check_field("tx_byte", 32'(e.tx), 32'(m_tdata[7:0]));
				bad |= check_field("write_address", e.addr, m_tdata[39:8]);
				bad |= check_field("write_data", e.data, m_tdata[71:40]);
				bad |= check_field("status", 32'(e.status), 32'(m_tdata[74:72]));
				bad |= check_field("last", 32'(e.last), 32'(m_tlast));
				if (bad)
					errors++;
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			if (hold_armed && results_seen >= 10) begin
				hold_armed = 0;
				m_tready <= 0;
				repeat (400) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	initial begin
		#10ms;
		$display("FAIL");
		$finish;
	end

	initial begin
		burst_row_t rows [5];
		int pick;
		int left;
		rows = '{
			'{SH_TIMEOUT, 8'h00, 0, PL_RANDOM, 1, xcr_pkg::B_NAK, 1, 32'h0000_0000},
			'{SH_SHORT, 8'h55, 3, PL_RANDOM, 1, xcr_pkg::B_ACK, 0, 32'h0},
			'{SH_FULL, xcr_pkg::B_SOH, 0, PL_ONES, 0, 8'h00, 1, 32'hFFFF_FFF0},
			'{SH_TIMEOUT, 8'h00, 0, PL_RANDOM, 0, 8'h00, 0, 32'h0},
			'{SH_SHORT, xcr_pkg::B_SOH, 1, PL_RANDOM, 1, xcr_pkg::B_ACK, 0, 32'h0}
		};
		rx_base = 0; rx_count = 0; rx_first = 0; rx_pnum = 0; rx_sum = 0; rx_seq = 0;
		rx_started = 0; rx_offset = 0; rx_halted = 0;
		foreach (rx_payload[i])
			rx_payload[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].set_base)
				write_base(rows[i].base);
			row_typed = rows[i].typed;
			row_tx = rows[i].exp_tx;
			case (rows[i].shape)
				SH_TIMEOUT: send_short(8'h00, 0);
				SH_SHORT: send_short(rows[i].first, rows[i].len);
				default: send_packet(rows[i].first, rx_seq + 8'd1, rows[i].fill, 1'b0);
			endcase
			row_typed = 0;
		end

		while (items_sent < ITEMS) begin
			left = ITEMS - items_sent;
			if (left < 100)
				quiet = 1;
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: write_base(32'h0);
					1: write_base(32'hFFFF_FFFF);
					default: write_base($urandom);
				endcase
			end
			pick = $urandom_range(0, 9);
			if (left < 133)
				pick = 8;
			if (pick < 7)
				send_packet(xcr_pkg::B_SOH, rx_seq + 8'd1, $urandom_range(0, 5) == 0 ?
					$urandom_range(1, 2) : PL_RANDOM, 1'b0);
			else if (pick == 7)
				send_short(8'h00, 0);
			else if (pick == 8)
				send_short(plain_first(), $urandom_range(1, left < 132 ? left - 1 : 131));
			else
				send_packet(plain_first(), 8'($urandom), PL_RANDOM, 1'b0);
		end

		case ($urandom_range(0, 3))
			0: send_short(xcr_pkg::B_EOT, $urandom_range(1, 4));
			1: send_short(xcr_pkg::B_CAN, $urandom_range(1, 4));
			2: send_packet(xcr_pkg::B_SOH, rx_seq + 8'd1, PL_RANDOM, 1'b1);
			default: send_packet(xcr_pkg::B_SOH, rx_seq + 8'd2, PL_RANDOM, 1'b0);
		endcase
		// after the stop everything is dropped
		send_short(xcr_pkg::B_SOH, 3);
		send_short(8'h00, 0);
		s_tvalid <= 0;

		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
